@@ design/mfc_pkg.sv @@
// ----------------------------------------------------------------------------
// Modem frame classifier package
// Shared types and constants for the reply-frame deframer and its top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mfc_pkg;

   // Frame lengths in bytes, counted from the first byte of the start word.
   localparam logic [7:0] LONG_FRAME_BYTES  = 8'd105;
   localparam logic [7:0] SHORT_FRAME_BYTES = 8'd10;

   // Byte positions within a frame that carry meaning.
   localparam logic [6:0] POS_FORM_BYTE   = 7'd4;
   localparam logic [6:0] POS_LAST_DIGIT  = 7'd8;
   localparam logic [6:0] POS_BYTE_NINE   = 7'd9;
   localparam logic [6:0] POS_END_FLAG    = 7'd50;
   localparam logic [6:0] POS_HEADER_MARK = 7'd104;

   // Start word and type digit strings.
   localparam logic [31:0] START_WORD    = 32'h4845_4144;  // "HEAD"
   localparam logic [31:0] DIGITS_DATA   = 32'h3030_3031;  // "0001"
   localparam logic [31:0] DIGITS_QUERY  = 32'h3939_3030;  // "9900"
   localparam logic [31:0] DIGITS_CONFIG = 32'h3930_3031;  // "9001"
   localparam logic [31:0] DIGITS_SPACE  = 32'h3930_3131;  // "9011"

   localparam logic [7:0] FORM_LONG    = 8'h58;  // 'X'
   localparam logic [7:0] FORM_SHORT   = 8'h59;  // 'Y'
   localparam logic [7:0] HEADER_VALUE = 8'h01;
   localparam int unsigned END_FLAG_BIT = 6;

   typedef enum logic [2:0] {
      FT_HEADER  = 3'd0,
      FT_DATA    = 3'd1,
      FT_QUERY   = 3'd2,
      FT_CONFIG  = 3'd3,
      FT_SPACE   = 3'd4,
      FT_UNKNOWN = 3'd5
   } frame_kind_type;

   typedef struct packed {
      frame_kind_type frame_type;
      logic           long_frame;
      logic [7:0]     byte_nine;
      logic           end_of_transmission;
   } result_type;

endpackage

@@ design/mfc_deframer.sv @@
// ----------------------------------------------------------------------------
// Modem frame deframer
// Tracks the byte position in a reply frame, keeps the start word, type
// digits, byte nine and the flags, and classifies the frame on its last byte or reports a bad start on the form byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mfc_deframer (
   input  logic               clock,
   input  logic               reset,
   input  logic               step_en,
   input  logic [7:0]         rx_byte,
   output logic               result_valid,
   output mfc_pkg::result_type result
);

   logic [6:0]  pos_ff,    pos_in;
   logic [31:0] start_ff,  start_in;
   logic [31:0] digits_ff, digits_in;
   logic [7:0]  nine_ff,   nine_in;
   logic        long_ff,   long_in;
   logic        eot_ff,    eot_in;
   logic        hdr_ff,    hdr_in;

   logic        first;
   logic [31:0] start_base, digits_base;
   logic [7:0]  nine_base;
   logic        long_base, eot_base, hdr_base;
   logic [7:0]  pos_next;
   logic [7:0]  frame_len;

   always_comb begin
      first       = (pos_ff == 7'd0);
      // Byte 0 of every frame starts from cleared values.
      start_base  = first ? 32'd0 : start_ff;
      digits_base = first ? 32'd0 : digits_ff;
      nine_base   = first ? 8'd0  : nine_ff;
      long_base   = first ? 1'b0  : long_ff;
      eot_base    = first ? 1'b0  : eot_ff;
      hdr_base    = first ? 1'b0  : hdr_ff;

      start_in  = start_base;
      digits_in = digits_base;
      nine_in   = nine_base;
      long_in   = long_base;
      eot_in    = eot_base;
      hdr_in    = hdr_base;
      pos_in    = pos_ff;
      pos_next  = {1'b0, pos_ff} + 8'd1;
      frame_len = long_base ? mfc_pkg::LONG_FRAME_BYTES : mfc_pkg::SHORT_FRAME_BYTES;

      result_valid               = 1'b0;
      result.frame_type          = mfc_pkg::FT_UNKNOWN;
      result.long_frame          = 1'b0;
      result.byte_nine           = 8'd0;
      result.end_of_transmission = 1'b0;

      priority if (pos_ff < mfc_pkg::POS_FORM_BYTE) begin
         start_in = {start_base[23:0], rx_byte};
         pos_in   = pos_next[6:0];
      end else if (pos_ff == mfc_pkg::POS_FORM_BYTE) begin
         if (start_base != mfc_pkg::START_WORD ||
             (rx_byte != mfc_pkg::FORM_LONG && rx_byte != mfc_pkg::FORM_SHORT)) begin
            // A bad start is reported straight away and the search restarts.
            result_valid = 1'b1;
            pos_in       = 7'd0;
         end else begin
            long_in = (rx_byte == mfc_pkg::FORM_LONG);
            pos_in  = pos_next[6:0];
         end
      end else begin
         if (pos_ff <= mfc_pkg::POS_LAST_DIGIT) begin
            digits_in = {digits_base[23:0], rx_byte};
         end
         if (pos_ff == mfc_pkg::POS_BYTE_NINE) begin
            nine_in = rx_byte;
         end
         if (long_base && pos_ff == mfc_pkg::POS_END_FLAG) begin
            eot_in = rx_byte[mfc_pkg::END_FLAG_BIT];
         end
         if (long_base && pos_ff == mfc_pkg::POS_HEADER_MARK) begin
            hdr_in = (rx_byte == mfc_pkg::HEADER_VALUE);
         end

         if (pos_next < frame_len) begin
            pos_in = pos_next[6:0];
         end else begin
            // Last byte: classify from the values including this byte.
            result_valid      = 1'b1;
            pos_in            = 7'd0;
            result.long_frame = long_base;
            result.byte_nine  = nine_in;
            priority if (digits_in == mfc_pkg::DIGITS_DATA) begin
               if (long_base && hdr_in) begin
                  result.frame_type = mfc_pkg::FT_HEADER;
               end else begin
                  result.frame_type          = mfc_pkg::FT_DATA;
                  result.end_of_transmission = long_base & eot_in;
               end
            end else if (digits_in == mfc_pkg::DIGITS_QUERY) begin
               result.frame_type = mfc_pkg::FT_QUERY;
            end else if (digits_in == mfc_pkg::DIGITS_CONFIG) begin
               result.frame_type = mfc_pkg::FT_CONFIG;
            end else if (digits_in == mfc_pkg::DIGITS_SPACE) begin
               result.frame_type = mfc_pkg::FT_SPACE;
            end else begin
               result.frame_type = mfc_pkg::FT_UNKNOWN;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= 7'd0;
         start_ff  <= 32'd0;
         digits_ff <= 32'd0;
         nine_ff   <= 8'd0;
         long_ff   <= 1'b0;
         eot_ff    <= 1'b0;
         hdr_ff    <= 1'b0;
      end else if (step_en) begin
         pos_ff    <= pos_in;
         start_ff  <= start_in;
         digits_ff <= digits_in;
         nine_ff   <= nine_in;
         long_ff   <= long_in;
         eot_ff    <= eot_in;
         hdr_ff    <= hdr_in;
      end
   end

endmodule

@@ design/modem_frame_classifier.sv @@
// ----------------------------------------------------------------------------
// Modem frame classifier
// Deframes modem reply frames from a received byte stream and reports the
// frame type, form, byte nine and end-of-transmission flag of each frame.
// ----------------------------------------------------------------------------
// One byte is taken per transfer and the block sustains one byte per clock
// cycle while the input side is not stalled. A byte passes through an input
// register, the deframer logic and a result register. The result is loaded
// into the result register from the byte in the input register that completes
// its frame (or the fifth byte of a bad start), and it is held until the
// result transfer. The input side keeps taking bytes while a result waits,
// and stalls only when a new result is due and the result register is still
// occupied. Nothing needs initialising after reset.
`timescale 1ns / 1ps

module modem_frame_classifier (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_frame_type,
   output logic       rsp_long_frame,
   output logic [7:0] rsp_byte_nine,
   output logic       rsp_end_of_transmission
);

   logic               in_valid_ff, in_valid_in;
   logic [7:0]         in_byte_ff;
   logic               out_valid_ff, out_valid_in;
   mfc_pkg::result_type out_ff;

   logic               take;
   logic               out_free;
   logic               step;
   logic               load;
   logic               dfr_valid;
   mfc_pkg::result_type dfr_result;

   mfc_deframer u_deframer (
      .clock        (clock),
      .reset        (reset),
      .step_en      (step),
      .rx_byte      (in_byte_ff),
      .result_valid (dfr_valid),
      .result       (dfr_result)
   );

   always_comb begin
      out_free     = !out_valid_ff || !rsp_stall;
      // The held byte moves on unless it makes a result with nowhere to go.
      step         = in_valid_ff && (!dfr_valid || out_free);
      load         = step && dfr_valid;
      req_stall    = in_valid_ff && !step;
      take         = req_valid && !req_stall;
      in_valid_in  = take || (in_valid_ff && !step);
      out_valid_in = load || (out_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_byte_ff <= req_rx_byte;
      end
      if (load) begin
         out_ff <= dfr_result;
      end
   end

   assign rsp_valid               = out_valid_ff;
   assign rsp_frame_type          = out_ff.frame_type;
   assign rsp_long_frame          = out_ff.long_frame;
   assign rsp_byte_nine           = out_ff.byte_nine;
   assign rsp_end_of_transmission = out_ff.end_of_transmission;

endmodule
